>>> rtl/cdt_pkg.sv
package cdt_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 3'd3;

    localparam int SQ_W   = 50;
    localparam int ROOT_W = 25;
    localparam int DIVN_W = 41;
    localparam int DIVD_W = 25;
    localparam int MUL_W  = 26;

    localparam logic FUNC_TICK = 1'b0;

    typedef enum logic [2:0] {
        V_THREAT      = 3'd0,
        V_NO_MOTION   = 3'd1,
        V_COINCIDENT  = 3'd2,
        V_OUT_RANGE   = 3'd3,
        V_RECEDING    = 3'd4,
        V_SLOW        = 3'd5,
        V_FULL        = 3'd6,
        V_TICK        = 3'd7
    } verdict_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQRT_V,
        S_SQRT_D,
        S_CHECK,
        S_PROD,
        S_DIVST,
        S_DIV,
        S_ESQ,
        S_EACC,
        S_SQRT_S,
        S_RECEDE,
        S_VV,
        S_SS,
        S_SQRT_C,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               func;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic        [31:0] now_ms;
        logic        [7:0]  object_id;
    } in_item_t;

    typedef struct packed {
        logic       is_threat;
        logic [3:0] threat_slot;
        logic [4:0] threat_total;
        logic       warn_event;
        logic [2:0] verdict;
        logic [7:0] echo_id;
    } out_item_t;

endpackage

>>> rtl/cdt_chan_if.sv
interface cdt_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cdt_isqrt.sv
module cdt_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cdt_pkg::SQ_W-1:0]  x,
    output logic                      done,
    output logic [cdt_pkg::ROOT_W-1:0] root
);
    import cdt_pkg::*;

    logic [SQ_W-1:0]     x_reg;
    logic [ROOT_W+2:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [4:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ROOT_W+4:0]   rem_sh;
    logic [ROOT_W+4:0]   trial;
    logic [ROOT_W+4:0]   diff;
    logic                ge;

    // Two radicand bits come down per step, one root bit goes out.
    always_comb
    begin
        rem_sh = {rem_reg, x_reg[SQ_W-1 -: 2]};
        trial  = {3'b000, root_reg, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[ROOT_W+2:0] : rem_sh[ROOT_W+2:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/cdt_divu.sv
module cdt_divu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cdt_pkg::DIVN_W-1:0] num,
    input  logic [cdt_pkg::DIVD_W-1:0] den,
    output logic                       done,
    output logic [cdt_pkg::DIVN_W-1:0] quot,
    output logic                       rem_nz
);
    import cdt_pkg::*;

    logic [DIVN_W-1:0] n_reg;
    logic [DIVD_W-1:0] d_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVD_W:0]   rem_sh;
    logic [DIVD_W:0]   diff;
    logic              ge;

    // Restoring division: one quotient bit per cycle shifts into the numerator.
    always_comb
    begin
        rem_sh = {rem_reg, n_reg[DIVN_W-1]};
        diff   = rem_sh - {1'b0, d_reg};
        ge     = (rem_sh >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIVN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num;
            d_reg   <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[DIVN_W-2:0], ge};
            rem_reg <= ge ? diff[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
        end
    end

    assign done   = done_reg;
    assign quot   = n_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

>>> rtl/closing_threat_detector_top.sv
// Channel   Dir   Payload      Handshake
// in_ch     in    in_item_t    valid/ready, taken when both are high
// out_ch    out   out_item_t   valid/ready, taken when both are high
// cfg_*     in    16-bit data  write when cfg_we is high, no back-pressure
//
// A tick-start request goes straight to the result state. An object that is skipped early
// ends after two roots; the run time of a full test is set by the bit-serial root unit (25 steps
// per root, four roots) and the restoring divider (41 steps, three quotients).
// One request is worked on at a time; the next is taken once the result is parked
// in the output register, which holds while the sink stalls. Reset is asynchronous.
module closing_threat_detector_top #(
    parameter int MAX_THREATS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cdt_chan_if.sink                      in_ch,
    cdt_chan_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdt_pkg::CFG_W-1:0]     cfg_data
);
    import cdt_pkg::*;

    localparam int CW = $clog2(MAX_THREATS + 1);

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;

    logic signed [23:0] own_pos_reg [3];
    logic signed [15:0] own_vel_reg [3];
    logic [31:0] tick_time_reg, tick_time_next;
    logic [31:0] last_warn_reg, last_warn_next;
    logic [CW-1:0] count_reg, count_next;

    logic signed [16:0] rv_reg [3];
    logic signed [24:0] dd_reg [3];
    logic [7:0] id_reg;

    logic [33:0] v2_reg, v2_next;
    logic [49:0] d2_reg, d2_next;
    logic [16:0] v_reg, v_next;
    logic [24:0] d_reg, d_next;
    logic [37:0] s2_reg, s2_next;
    logic [18:0] s_reg, s_next;
    logic [37:0] t_reg, t_next;
    logic signed [2*MUL_W-1:0] prod_reg, prod_next;
    logic neg_reg, neg_next;
    logic signed [19:0] e_reg, e_next;

    logic [15:0] rmin_reg, rmax_reg, hold_reg;
    logic [14:0] csmin_reg;

    logic res_threat_reg, res_threat_next;
    logic [3:0] res_slot_reg, res_slot_next;
    logic res_warn_reg, res_warn_next;
    verdict_t res_verdict_reg, res_verdict_next;

    logic out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic load_own, load_obj;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [1:0] m_idx;
    logic sq_start, sq_done;
    logic [SQ_W-1:0] sq_x;
    logic [ROOT_W-1:0] sq_root;
    logic div_start, div_done, div_nz;
    logic [DIVN_W-1:0] div_n, div_q;
    logic [2*MUL_W-1:0] prod_mag;
    logic signed [19:0] q_val;
    logic signed [19:0] u_val;
    logic [28:0] lhs_rec, rhs_rec;
    logic [23:0] c_val;
    logic [31:0] elapsed;

    cdt_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (sq_x),
        .done  (sq_done),
        .root  (sq_root)
    );

    cdt_divu u_divu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_n),
        .den    (d_reg),
        .done   (div_done),
        .quot   (div_q),
        .rem_nz (div_nz)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            tick_time_reg <= '0;
            last_warn_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rmin_reg      <= 16'd100;
            rmax_reg      <= 16'd5000;
            csmin_reg     <= 15'd1000;
            hold_reg      <= 16'd5000;
            for (int i = 0; i < 3; i++)
            begin
                own_pos_reg[i] <= '0;
                own_vel_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            tick_time_reg <= tick_time_next;
            last_warn_reg <= last_warn_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (load_own)
            begin
                own_pos_reg[0] <= in_ch.data.pos_x;
                own_pos_reg[1] <= in_ch.data.pos_y;
                own_pos_reg[2] <= in_ch.data.pos_z;
                own_vel_reg[0] <= in_ch.data.vel_x;
                own_vel_reg[1] <= in_ch.data.vel_y;
                own_vel_reg[2] <= in_ch.data.vel_z;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RANGE_MIN: rmin_reg  <= cfg_data;
                    CFG_RANGE_MAX: rmax_reg  <= cfg_data;
                    CFG_CLOSE_MIN: csmin_reg <= cfg_data[14:0];
                    CFG_HOLDOFF:   hold_reg  <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v2_reg          <= v2_next;
        d2_reg          <= d2_next;
        v_reg           <= v_next;
        d_reg           <= d_next;
        s2_reg          <= s2_next;
        s_reg           <= s_next;
        t_reg           <= t_next;
        prod_reg        <= prod_next;
        neg_reg         <= neg_next;
        e_reg           <= e_next;
        res_threat_reg  <= res_threat_next;
        res_slot_reg    <= res_slot_next;
        res_warn_reg    <= res_warn_next;
        res_verdict_reg <= res_verdict_next;
        out_data_reg    <= out_data_next;
        if (load_own || load_obj)
        begin
            id_reg <= in_ch.data.object_id;
        end
        if (load_obj)
        begin
            rv_reg[0] <= 17'(in_ch.data.vel_x) - 17'(own_vel_reg[0]);
            rv_reg[1] <= 17'(in_ch.data.vel_y) - 17'(own_vel_reg[1]);
            rv_reg[2] <= 17'(in_ch.data.vel_z) - 17'(own_vel_reg[2]);
            dd_reg[0] <= 25'(own_pos_reg[0]) - 25'(in_ch.data.pos_x);
            dd_reg[1] <= 25'(own_pos_reg[1]) - 25'(in_ch.data.pos_y);
            dd_reg[2] <= 25'(own_pos_reg[2]) - 25'(in_ch.data.pos_z);
        end
    end

    // Shared datapath helpers.
    always_comb
    begin
        prod_mag = prod_reg[2*MUL_W-1] ? 52'(-prod_reg) : 52'(prod_reg);
        div_n    = prod_mag[DIVN_W-1:0];
        q_val    = $signed({1'b0, div_q[18:0]});
        u_val    = q_val + $signed({19'b0, div_nz});
        lhs_rec  = 29'(s_reg) * 29'd1000;
        rhs_rec  = 29'(v_reg) * 29'd1414;
        c_val    = sq_root[ROOT_W-1:1];
        elapsed  = tick_time_reg - last_warn_reg;
        m_idx    = (cnt_reg < 3'd3) ? cnt_reg[1:0] : 2'(cnt_reg - 3'd3);
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        tick_time_next   = tick_time_reg;
        last_warn_next   = last_warn_reg;
        count_next       = count_reg;
        v2_next          = v2_reg;
        d2_next          = d2_reg;
        v_next           = v_reg;
        d_next           = d_reg;
        s2_next          = s2_reg;
        s_next           = s_reg;
        t_next           = t_reg;
        neg_next         = neg_reg;
        e_next           = e_reg;
        res_threat_next  = res_threat_reg;
        res_slot_next    = res_slot_reg;
        res_warn_next    = res_warn_reg;
        res_verdict_next = res_verdict_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        load_own         = 1'b0;
        load_obj         = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        sq_start         = 1'b0;
        sq_x             = '0;
        div_start        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    res_threat_next = 1'b0;
                    res_slot_next   = '0;
                    res_warn_next   = 1'b0;
                    if (in_ch.data.func == FUNC_TICK)
                    begin
                        load_own         = 1'b1;
                        tick_time_next   = in_ch.data.now_ms;
                        count_next       = '0;
                        res_verdict_next = V_TICK;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        load_obj   = 1'b1;
                        v2_next    = '0;
                        d2_next    = '0;
                        cnt_next   = '0;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                // Squares go one per cycle; each sum adds the product held in prod_reg.
                if (cnt_reg < 3'd3)
                begin
                    mul_a = MUL_W'(rv_reg[m_idx]);
                end
                else if (cnt_reg < 3'd6)
                begin
                    mul_a = MUL_W'(dd_reg[m_idx]);
                end
                mul_b = mul_a;
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd3)
                begin
                    v2_next = v2_reg + prod_reg[33:0];
                end
                if (cnt_reg >= 3'd4)
                begin
                    d2_next = d2_reg + prod_reg[49:0];
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6)
                begin
                    sq_start   = 1'b1;
                    sq_x       = SQ_W'(v2_reg);
                    state_next = S_SQRT_V;
                end
            end
            S_SQRT_V:
            begin
                if (sq_done)
                begin
                    v_next     = sq_root[16:0];
                    sq_start   = 1'b1;
                    sq_x       = d2_reg;
                    state_next = S_SQRT_D;
                end
            end
            S_SQRT_D:
            begin
                if (sq_done)
                begin
                    d_next     = sq_root;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                k_next  = '0;
                s2_next = '0;
                if (v2_reg == '0)
                begin
                    res_verdict_next = V_NO_MOTION;
                    state_next       = S_DONE;
                end
                else if (d2_reg == '0)
                begin
                    res_verdict_next = V_COINCIDENT;
                    state_next       = S_DONE;
                end
                else if (d_reg < 25'(rmin_reg) || d_reg > 25'(rmax_reg))
                begin
                    res_verdict_next = V_OUT_RANGE;
                    state_next       = S_DONE;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                mul_a      = MUL_W'(dd_reg[k_reg]);
                mul_b      = $signed({9'b0, v_reg});
                state_next = S_DIVST;
            end
            S_DIVST:
            begin
                div_start  = 1'b1;
                neg_next   = prod_reg[2*MUL_W-1];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // A negative quotient rounds toward minus infinity.
                    if (neg_reg)
                    begin
                        e_next = -u_val - 20'(rv_reg[k_reg]);
                    end
                    else
                    begin
                        e_next = q_val - 20'(rv_reg[k_reg]);
                    end
                    state_next = S_ESQ;
                end
            end
            S_ESQ:
            begin
                mul_a      = MUL_W'(e_reg);
                mul_b      = MUL_W'(e_reg);
                state_next = S_EACC;
            end
            S_EACC:
            begin
                s2_next = s2_reg + prod_reg[37:0];
                if (k_reg == 2'd2)
                begin
                    sq_start   = 1'b1;
                    sq_x       = SQ_W'(s2_next);
                    state_next = S_SQRT_S;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_PROD;
                end
            end
            S_SQRT_S:
            begin
                if (sq_done)
                begin
                    s_next     = sq_root[18:0];
                    state_next = S_RECEDE;
                end
            end
            S_RECEDE:
            begin
                if (lhs_rec > rhs_rec)
                begin
                    res_verdict_next = V_RECEDING;
                    state_next       = S_DONE;
                end
                else
                begin
                    mul_a      = $signed({9'b0, v_reg});
                    mul_b      = $signed({9'b0, v_reg});
                    state_next = S_VV;
                end
            end
            S_VV:
            begin
                t_next     = {prod_reg[35:0], 2'b00};
                mul_a      = $signed({7'b0, s_reg});
                mul_b      = $signed({7'b0, s_reg});
                state_next = S_SS;
            end
            S_SS:
            begin
                sq_start   = 1'b1;
                sq_x       = SQ_W'(t_reg - prod_reg[37:0]);
                state_next = S_SQRT_C;
            end
            S_SQRT_C:
            begin
                if (sq_done)
                begin
                    state_next = S_DONE;
                    if (c_val < 24'(csmin_reg))
                    begin
                        res_verdict_next = V_SLOW;
                    end
                    else if (count_reg >= CW'(MAX_THREATS))
                    begin
                        res_verdict_next = V_FULL;
                    end
                    else
                    begin
                        res_verdict_next = V_THREAT;
                        res_threat_next  = 1'b1;
                        res_slot_next    = 4'(count_reg);
                        count_next       = count_reg + CW'(1);
                        if (elapsed > 32'(hold_reg))
                        begin
                            last_warn_next = tick_time_reg;
                            res_warn_next  = 1'b1;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.is_threat    = res_threat_reg;
                    out_data_next.threat_slot  = res_slot_reg;
                    out_data_next.threat_total =
                        (res_verdict_reg == V_TICK) ? 5'd0 : 5'(count_reg);
                    out_data_next.warn_event   = res_warn_reg;
                    out_data_next.verdict      = res_verdict_reg;
                    out_data_next.echo_id      = id_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_THREATS))
        else $error("threat count beyond limit");

    a_threat_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.is_threat |-> out_data_reg.verdict == V_THREAT)
        else $error("threat flag without threat verdict");

    a_warn_threat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.warn_event |-> out_data_reg.is_threat)
        else $error("warning without threat");

    a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.data.func == FUNC_TICK |=> count_reg == '0)
        else $error("tick start did not clear count");

endmodule

>>> sim/tb_top.sv
module tb_top;
    import cdt_pkg::*;

    localparam int MAX_THREATS = 16;
    localparam int SETTLE_CYCLES = 320;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 265;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    cdt_chan_if #(.payload_t(in_item_t)) in_bus ();
    cdt_chan_if #(.payload_t(out_item_t)) out_bus ();

    closing_threat_detector_top #(.MAX_THREATS(MAX_THREATS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_bus),
        .out_ch   (out_bus),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    class threat_scoreboard;
        out_item_t pending_q[$];
        int errors;
        longint owner_pos[3];
        longint owner_vel[3];
        bit [31:0] tick_ms;
        bit [31:0] last_warn_ms;
        int unsigned count;
        bit [15:0] rmin;
        bit [15:0] rmax;
        bit [14:0] cmin;
        bit [15:0] holdoff;

        function new();
            errors = 0;
            for (int i = 0; i < 3; i++)
            begin
                owner_pos[i] = 0;
                owner_vel[i] = 0;
            end
            tick_ms = 0;
            last_warn_ms = 0;
            count = 0;
            rmin = 100;
            rmax = 5000;
            cmin = 1000;
            holdoff = 5000;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_RANGE_MIN: rmin = val;
                CFG_RANGE_MAX: rmax = val;
                CFG_CLOSE_MIN: cmin = val[14:0];
                CFG_HOLDOFF:   holdoff = val;
                default: ;
            endcase
        endfunction

        function longint unsigned int_root(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint div_down(longint num, longint den);
            if (num >= 0)
                return num / den;
            return -((-num + den - 1) / den);
        endfunction

        function void note_request(in_item_t it);
            out_item_t r;
            longint p[3];
            longint vl[3];
            longint rv[3];
            longint dd[3];
            longint u;
            longint e;
            longint unsigned v2;
            longint unsigned d2;
            longint unsigned s2;
            longint unsigned v;
            longint unsigned d;
            longint unsigned s;
            longint unsigned c;
            verdict_t vd;
            p[0] = it.pos_x;
            p[1] = it.pos_y;
            p[2] = it.pos_z;
            vl[0] = it.vel_x;
            vl[1] = it.vel_y;
            vl[2] = it.vel_z;
            r = '0;
            r.echo_id = it.object_id;
            if (it.func == FUNC_TICK)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    owner_pos[i] = p[i];
                    owner_vel[i] = vl[i];
                end
                tick_ms = it.now_ms;
                count = 0;
                vd = V_TICK;
            end
            else
            begin
                v2 = 0;
                d2 = 0;
                s2 = 0;
                for (int i = 0; i < 3; i++)
                begin
                    rv[i] = vl[i] - owner_vel[i];
                    dd[i] = owner_pos[i] - p[i];
                    v2 += rv[i] * rv[i];
                    d2 += dd[i] * dd[i];
                end
                v = int_root(v2);
                d = int_root(d2);
                if (v2 == 0)
                    vd = V_NO_MOTION;
                else if (d2 == 0)
                    vd = V_COINCIDENT;
                else if (d < rmin || d > rmax)
                    vd = V_OUT_RANGE;
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u = div_down(dd[i] * longint'(v), longint'(d));
                        e = u - rv[i];
                        s2 += e * e;
                    end
                    s = int_root(s2);
                    if (1000 * s > 1414 * v)
                        vd = V_RECEDING;
                    else
                    begin
                        c = int_root(4 * v * v - s * s) >> 1;
                        if (c < cmin)
                            vd = V_SLOW;
                        else if (count >= MAX_THREATS)
                            vd = V_FULL;
                        else
                        begin
                            vd = V_THREAT;
                            r.is_threat = 1'b1;
                            r.threat_slot = count[3:0];
                            count++;
                            if (32'(tick_ms - last_warn_ms) > holdoff)
                            begin
                                last_warn_ms = tick_ms;
                                r.warn_event = 1'b1;
                            end
                        end
                    end
                end
                r.threat_total = count[4:0];
            end
            r.verdict = vd;
            pending_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want, logic [7:0] id);
            $display("mismatch id %0d: %s got %0d expected %0d", id, what, got, want);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t w;
            if (pending_q.size() == 0)
            begin
                report("unexpected result", 1, 0, got.echo_id);
                return;
            end
            w = pending_q.pop_front();
            if (got.is_threat !== w.is_threat)
                report("is_threat", 32'(got.is_threat), 32'(w.is_threat), w.echo_id);
            if (got.threat_slot !== w.threat_slot)
                report("threat_slot", 32'(got.threat_slot), 32'(w.threat_slot), w.echo_id);
            if (got.threat_total !== w.threat_total)
                report("threat_total", 32'(got.threat_total), 32'(w.threat_total),
                       w.echo_id);
            if (got.warn_event !== w.warn_event)
                report("warn_event", 32'(got.warn_event), 32'(w.warn_event), w.echo_id);
            if (got.verdict !== w.verdict)
                report("verdict", 32'(got.verdict), 32'(w.verdict), w.echo_id);
            if (got.echo_id !== w.echo_id)
                report("echo_id", 32'(got.echo_id), 32'(w.echo_id), w.echo_id);
        endtask
    endclass

    threat_scoreboard sb = new();
    int tx_idle;
    int rx_idle;
    int quiet_cycles;
    bit [31:0] now_cursor;
    longint own_p[3];
    longint own_v[3];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: check on handshake, random back-pressure, and the stall watchdog.
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            sb.check_result(out_bus.data);
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("closing_threat_detector_top regression: fail");
            $finish;
        end
        out_bus.ready <= ($urandom_range(99) >= rx_idle);
    end

    task send_request(in_item_t it);
        while ($urandom_range(99) < tx_idle)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data <= it;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        sb.note_request(it);
        if (it.func == FUNC_TICK)
            for (int i = 0; i < 3; i++)
            begin
                own_p[i] = (i == 0) ? it.pos_x : (i == 1) ? it.pos_y : it.pos_z;
                own_v[i] = (i == 0) ? it.vel_x : (i == 1) ? it.vel_y : it.vel_z;
            end
    endtask

    task drain_block();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic in_item_t make_item(bit f, longint px, longint py, longint pz,
                                           longint vx, longint vy, longint vz,
                                           bit [31:0] t, bit [7:0] id);
        in_item_t it;
        it.func = f;
        it.pos_x = 24'(px);
        it.pos_y = 24'(py);
        it.pos_z = 24'(pz);
        it.vel_x = 16'(vx);
        it.vel_y = 16'(vy);
        it.vel_z = 16'(vz);
        it.now_ms = t;
        it.object_id = id;
        return it;
    endfunction

    function automatic longint rand_span(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly geometry that lands in the range window and points at the owner,
    // with tick starts, receding, noisy and fully random requests mixed in.
    function automatic in_item_t random_request();
        in_item_t it;
        longint dd[3];
        longint rv[3];
        longint m;
        int scale;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            now_cursor = now_cursor + $urandom_range(12000);
            return make_item(FUNC_TICK, rand_span(4000000), rand_span(4000000),
                             rand_span(4000000), rand_span(5000), rand_span(5000),
                             rand_span(5000), now_cursor, 8'($urandom_range(255)));
        end
        if (pick < 22)
        begin
            it = {1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, $urandom};
            if (it.func == FUNC_TICK)
                now_cursor = it.now_ms;
            return it;
        end
        case ($urandom_range(3))
            0: scale = 200;
            1, 2: scale = 3000;
            default: scale = 40000;
        endcase
        m = longint'($urandom_range(20000));
        if ($urandom_range(5) == 0)
            m = -m;
        for (int i = 0; i < 3; i++)
        begin
            dd[i] = rand_span(scale);
            rv[i] = dd[i] * m / scale + rand_span($urandom_range(1) ? 20 : 600);
        end
        return make_item(1'b1, own_p[0] - dd[0], own_p[1] - dd[1], own_p[2] - dd[2],
                         own_v[0] + rv[0], own_v[1] + rv[1], own_v[2] + rv[2],
                         $urandom, 8'($urandom_range(255)));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.data = '0;
        out_bus.ready = 1'b0;
        tx_idle = 9;
        rx_idle = 82;
        quiet_cycles = 0;
        now_cursor = 0;
        for (int i = 0; i < 3; i++)
        begin
            own_p[i] = 0;
            own_v[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An object seen before any tick uses the zeroed owner state.
        send_request(make_item(1'b1, -1000, 0, 0, 2000, 0, 0, 0, 8'd1));
        send_request(make_item(FUNC_TICK, 8388607, -8388608, 0, 32767, -32768, 0,
                               32'hFFFF_FFFF, 8'd255));
        send_request(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0, 32'd9000, 8'd2));
        send_request(make_item(1'b1, -500, 0, 0, 0, 0, 0, 0, 8'd3));
        send_request(make_item(1'b1, 0, 0, 0, 1500, 0, 0, 0, 8'd4));
        send_request(make_item(1'b1, -50, 0, 0, 2000, 0, 0, 0, 8'd5));
        send_request(make_item(1'b1, -8388608, 8388607, -8388608, 0, 0, 0, 0, 8'd6));
        send_request(make_item(1'b1, -1000, 0, 0, -2000, 0, 0, 0, 8'd7));
        send_request(make_item(1'b1, -1000, 0, 0, 500, 0, 0, 0, 8'd8));
        send_request(make_item(1'b1, 0, -1000, 0, 32767, 32767, -32768, 0, 8'd9));
        // Seventeen direct approaches: with one threat already counted, the last two find every slot taken.
        for (int k = 0; k < 17; k++)
            send_request(make_item(1'b1, -1000 - k, 0, 0, 2000, 0, 0, 0, 8'(20 + k)));
        drain_block();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_RANGE_MIN, 16'd0);
                    write_reg(CFG_RANGE_MAX, 16'hFFFF);
                    write_reg(CFG_CLOSE_MIN, 16'd0);
                    write_reg(CFG_HOLDOFF, 16'd0);
                end
                1:
                begin
                    write_reg(CFG_RANGE_MIN, 16'd100);
                    write_reg(CFG_RANGE_MAX, 16'd5000);
                    write_reg(CFG_CLOSE_MIN, 16'hFFFF);
                    write_reg(CFG_HOLDOFF, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_RANGE_MIN, 16'd3000);
                    write_reg(CFG_RANGE_MAX, 16'd200);
                    write_reg(3'd5, 16'h1234);
                end
                3:
                begin
                    write_reg(CFG_RANGE_MIN, 16'd50);
                    write_reg(CFG_RANGE_MAX, 16'd60000);
                    write_reg(CFG_CLOSE_MIN, 16'h8000 | 16'(300));
                    write_reg(CFG_HOLDOFF, 16'd4000);
                end
                default:
                begin
                    write_reg(CFG_RANGE_MIN, 16'($urandom_range(500)));
                    write_reg(CFG_RANGE_MAX, 16'($urandom_range(2000, 65535)));
                    write_reg(CFG_CLOSE_MIN, 16'($urandom_range(4000)));
                    write_reg(CFG_HOLDOFF, 16'($urandom));
                end
            endcase
            case (ph % 3)
                0:
                begin
                    tx_idle = 9;
                    rx_idle = 82;
                end
                1:
                begin
                    tx_idle = 82;
                    rx_idle = 9;
                end
                default:
                begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(random_request());
            drain_block();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("closing_threat_detector_top regression: pass");
        else
            $display("closing_threat_detector_top regression: fail");
        $finish;
    end
endmodule
